[hw/rtl/clx_pkg.sv]
`timescale 1ns / 1ps
package clx_pkg;

  localparam int POSITION_BITS_DEF = 16;
  localparam int VALUE_BITS_DEF    = 31;
  localparam int QUEUE_DEPTH       = 4;
  localparam int KW_MAX_LEN        = 6;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_WORD,
    MODE_NUMBER,
    MODE_OP,
    MODE_ERROR
  } scan_mode_e;

  typedef enum logic [3:0] {
    KIND_OP,
    KIND_IDENT,
    KIND_NUMBER,
    KIND_RETURN,
    KIND_IF,
    KIND_ELSE,
    KIND_WHILE,
    KIND_FOR,
    KIND_END,
    KIND_ERROR
  } tok_kind_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_LPAREN,
    OP_RPAREN,
    OP_LT,
    OP_GT,
    OP_ASSIGN,
    OP_SEMI,
    OP_EQ,
    OP_NE,
    OP_LE,
    OP_GE
  } op_code_e;

  typedef struct packed {
    logic [3:0]                    token_kind;
    logic [3:0]                    op_code;
    logic [POSITION_BITS_DEF-1:0]  start_res;
    logic [POSITION_BITS_DEF-1:0]  length;
    logic [VALUE_BITS_DEF-1:0]     number_value;
    logic                          saturated;
    logic                          last;
  } tok_def_t;

  function automatic op_code_e single_op(input logic [7:0] c);
    unique case (c)
      "+":     single_op = OP_ADD;
      "-":     single_op = OP_SUB;
      "*":     single_op = OP_MUL;
      "/":     single_op = OP_DIV;
      "(":     single_op = OP_LPAREN;
      ")":     single_op = OP_RPAREN;
      "<":     single_op = OP_LT;
      ">":     single_op = OP_GT;
      "=":     single_op = OP_ASSIGN;
      ";":     single_op = OP_SEMI;
      default: single_op = OP_NONE;
    endcase
  endfunction

  function automatic op_code_e pair_op(input logic [7:0] c);
    unique case (c)
      "=":     pair_op = OP_EQ;
      "!":     pair_op = OP_NE;
      "<":     pair_op = OP_LE;
      default: pair_op = OP_GE;
    endcase
  endfunction

  // The length argument is zero when the word is too long to be a keyword.
  function automatic tok_kind_e kw_kind(input logic [KW_MAX_LEN-1:0][7:0] w,
                                        input logic [2:0] n);
    kw_kind = KIND_IDENT;
    if (n == 3'd2 && w[0] == "i" && w[1] == "f") begin
      kw_kind = KIND_IF;
    end
    if (n == 3'd3 && w[0] == "f" && w[1] == "o" && w[2] == "r") begin
      kw_kind = KIND_FOR;
    end
    if (n == 3'd4 && w[0] == "e" && w[1] == "l" && w[2] == "s" && w[3] == "e") begin
      kw_kind = KIND_ELSE;
    end
    if (n == 3'd5 && w[0] == "w" && w[1] == "h" && w[2] == "i" && w[3] == "l" &&
        w[4] == "e") begin
      kw_kind = KIND_WHILE;
    end
    if (n == 3'd6 && w[0] == "r" && w[1] == "e" && w[2] == "t" && w[3] == "u" &&
        w[4] == "r" && w[5] == "n") begin
      kw_kind = KIND_RETURN;
    end
  endfunction

endpackage

[hw/rtl/clx_in_if.sv]
`timescale 1ns / 1ps
interface clx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       is_end;

  modport source (output valid, output ch, output is_end, input ready);
  modport sink (input valid, input ch, input is_end, output ready);
endinterface

[hw/rtl/clx_tok_if.sv]
`timescale 1ns / 1ps
interface clx_tok_if #(
  parameter int PosBits = 16,
  parameter int ValBits = 31
);
  logic               valid;
  logic               ready;
  logic [3:0]         token_kind;
  logic [3:0]         op_code;
  logic [PosBits-1:0] start_res;
  logic [PosBits-1:0] length;
  logic [ValBits-1:0] number_value;
  logic               saturated;
  logic               last;

  modport source (output valid, output token_kind, output op_code, output start_res,
                  output length, output number_value, output saturated, output last,
                  input ready);
  modport sink (input valid, input token_kind, input op_code, input start_res,
                input length, input number_value, input saturated, input last,
                output ready);
endinterface

[hw/rtl/clx_front.sv]
`timescale 1ns / 1ps
module clx_front import clx_pkg::*; #(
  parameter int  PosBits = POSITION_BITS_DEF,
  parameter int  ValBits = VALUE_BITS_DEF,
  parameter type tok_t   = tok_def_t
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  clx_in_if.sink   src_i,
  input  logic     queue_room_i,
  output tok_t     tok_a_o,
  output logic     tok_a_vld_o,
  output tok_t     tok_b_o,
  output logic     tok_b_vld_o
);

  scan_mode_e                         mode_q, mode_d;
  logic [PosBits-1:0]                 pos_q, pos_d;
  logic [PosBits-1:0]                 start_q, start_d;
  logic [PosBits-1:0]                 len_q, len_d;
  logic [KW_MAX_LEN-1:0][7:0]         wbytes_q, wbytes_d;
  logic [ValBits-1:0]                 acc_q, acc_d;
  logic                               ovf_q, ovf_d;
  logic [7:0]                         pend_q, pend_d;

  logic               fire, is_end;
  logic [7:0]         ch;
  logic               is_letter, is_digit, is_space, is_cmp;
  op_code_e           sop;
  logic               op_pair, op_bang, restart;
  logic [PosBits-1:0] len_inc;
  logic [2:0]         kw_len;
  logic [ValBits+3:0] prod;

  assign src_i.ready = queue_room_i;
  assign fire        = src_i.valid && queue_room_i;
  assign is_end      = src_i.is_end;
  assign ch          = src_i.ch;

  assign is_letter = (ch >= "a" && ch <= "z") || (ch >= "A" && ch <= "Z") || ch == "_";
  assign is_digit  = ch >= "0" && ch <= "9";
  assign is_space  = ch == " " || (ch >= 8'd9 && ch <= 8'd13);
  assign is_cmp    = ch == "<" || ch == ">" || ch == "=" || ch == "!";
  assign sop       = single_op(ch);

  assign op_pair = mode_q == MODE_OP && ch == "=";
  assign op_bang = mode_q == MODE_OP && !op_pair && pend_q == "!";
  assign restart = !is_end &&
                   (mode_q == MODE_IDLE ||
                    (mode_q == MODE_WORD && !is_letter) ||
                    (mode_q == MODE_NUMBER && !is_digit) ||
                    (mode_q == MODE_OP && !op_pair && !op_bang));

  assign len_inc = (len_q == '1) ? len_q : len_q + PosBits'(1);
  assign kw_len  = (len_q <= PosBits'(KW_MAX_LEN)) ? len_q[2:0] : 3'd0;
  assign prod    = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + (ValBits+4)'(ch[3:0]);

  always_comb begin : next_state
    mode_d = mode_q;
    if (fire) begin
      if (is_end) begin
        mode_d = MODE_IDLE;
      end else if (op_pair) begin
        mode_d = MODE_IDLE;
      end else if (op_bang || mode_q == MODE_ERROR) begin
        mode_d = MODE_ERROR;
      end else if (restart) begin
        if (is_space) begin
          mode_d = MODE_IDLE;
        end else if (is_letter) begin
          mode_d = MODE_WORD;
        end else if (is_digit) begin
          mode_d = MODE_NUMBER;
        end else if (is_cmp) begin
          mode_d = MODE_OP;
        end else if (sop != OP_NONE) begin
          mode_d = MODE_IDLE;
        end else begin
          mode_d = MODE_ERROR;
        end
      end
    end
  end

  always_comb begin : datapath_next
    pos_d    = pos_q;
    start_d  = start_q;
    len_d    = len_q;
    wbytes_d = wbytes_q;
    acc_d    = acc_q;
    ovf_d    = ovf_q;
    pend_d   = pend_q;
    if (fire) begin
      pos_d = is_end ? '0 : pos_q + PosBits'(1);
      if (!is_end && mode_q == MODE_WORD && is_letter) begin
        if (len_q < PosBits'(KW_MAX_LEN)) begin
          wbytes_d[len_q[2:0]] = ch;
        end
        len_d = len_inc;
      end
      if (!is_end && mode_q == MODE_NUMBER && is_digit) begin
        if (prod[ValBits+3:ValBits] != 4'd0) begin
          acc_d = '1;
          ovf_d = 1'b1;
        end else begin
          acc_d = prod[ValBits-1:0];
        end
        len_d = len_inc;
      end
      if (restart && is_letter) begin
        start_d     = pos_q;
        len_d       = PosBits'(1);
        wbytes_d    = '0;
        wbytes_d[0] = ch;
      end
      if (restart && is_digit) begin
        start_d = pos_q;
        len_d   = PosBits'(1);
        acc_d   = ValBits'(ch[3:0]);
        ovf_d   = 1'b0;
      end
      if (restart && is_cmp) begin
        start_d = pos_q;
        pend_d  = ch;
      end
    end
  end

  always_comb begin : token_out
    tok_a_o     = '0;
    tok_b_o     = '0;
    tok_a_vld_o = 1'b0;
    tok_b_vld_o = 1'b0;
    unique case (mode_q)
      MODE_WORD: begin
        if (is_end || !is_letter) begin
          tok_a_vld_o        = 1'b1;
          tok_a_o.token_kind = (is_end || !is_digit) ? kw_kind(wbytes_q, kw_len) : KIND_IDENT;
          tok_a_o.start_res  = start_q;
          tok_a_o.length     = len_q;
        end
      end
      MODE_NUMBER: begin
        if (is_end || !is_digit) begin
          tok_a_vld_o          = 1'b1;
          tok_a_o.token_kind   = KIND_NUMBER;
          tok_a_o.start_res    = start_q;
          tok_a_o.length       = len_q;
          tok_a_o.number_value = acc_q;
          tok_a_o.saturated    = ovf_q;
        end
      end
      MODE_OP: begin
        tok_a_vld_o       = 1'b1;
        tok_a_o.start_res = start_q;
        tok_a_o.length    = PosBits'(1);
        if (!is_end && op_pair) begin
          tok_a_o.token_kind = KIND_OP;
          tok_a_o.op_code    = pair_op(pend_q);
          tok_a_o.length     = PosBits'(2);
        end else if (pend_q == "!") begin
          tok_a_o.token_kind = KIND_ERROR;
        end else begin
          tok_a_o.token_kind = KIND_OP;
          tok_a_o.op_code    = single_op(pend_q);
        end
      end
      default: ;
    endcase

    if (is_end) begin
      tok_b_vld_o        = 1'b1;
      tok_b_o.token_kind = KIND_END;
      tok_b_o.start_res  = pos_q;
      tok_b_o.last       = 1'b1;
    end else if (restart && !is_space && !is_letter && !is_digit && !is_cmp) begin
      tok_b_vld_o       = 1'b1;
      tok_b_o.start_res = pos_q;
      tok_b_o.length    = PosBits'(1);
      if (sop != OP_NONE) begin
        tok_b_o.token_kind = KIND_OP;
        tok_b_o.op_code    = sop;
      end else begin
        tok_b_o.token_kind = KIND_ERROR;
      end
    end

    tok_a_vld_o = tok_a_vld_o && fire;
    tok_b_vld_o = tok_b_vld_o && fire;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      pos_q    <= '0;
      start_q  <= '0;
      len_q    <= '0;
      wbytes_q <= '0;
      acc_q    <= '0;
      ovf_q    <= 1'b0;
      pend_q   <= '0;
    end else begin
      mode_q   <= mode_d;
      pos_q    <= pos_d;
      start_q  <= start_d;
      len_q    <= len_d;
      wbytes_q <= wbytes_d;
      acc_q    <= acc_d;
      ovf_q    <= ovf_d;
      pend_q   <= pend_d;
    end
  end

endmodule

[hw/rtl/clx_queue.sv]
`timescale 1ns / 1ps
module clx_queue import clx_pkg::*; #(
  parameter type tok_t = tok_def_t
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  tok_t      tok_a_i,
  input  logic      tok_a_vld_i,
  input  tok_t      tok_b_i,
  input  logic      tok_b_vld_i,
  output logic      room_o,
  clx_tok_if.source tok_o
);

  localparam int PtrBits = $clog2(QUEUE_DEPTH);
  localparam int CntBits = $clog2(QUEUE_DEPTH + 1);

  tok_t               mem_q [QUEUE_DEPTH];
  logic [PtrBits-1:0] wr_q, wr_d, rd_q, rd_d, wr_next;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic [1:0]         push_n;
  logic               pop;
  logic               out_vld_q, out_vld_d;
  tok_t               out_q;

  function automatic logic [PtrBits-1:0] ptr_inc(input logic [PtrBits-1:0] p);
    ptr_inc = (p == PtrBits'(QUEUE_DEPTH - 1)) ? '0 : p + PtrBits'(1);
  endfunction

  assign room_o  = cnt_q <= CntBits'(QUEUE_DEPTH - 2);
  assign push_n  = {1'b0, tok_a_vld_i} + {1'b0, tok_b_vld_i};
  assign pop     = (cnt_q != '0) && (!out_vld_q || tok_o.ready);
  assign wr_next = ptr_inc(wr_q);

  always_comb begin
    wr_d = wr_q;
    if (push_n == 2'd1) begin
      wr_d = wr_next;
    end else if (push_n == 2'd2) begin
      wr_d = ptr_inc(wr_next);
    end
    rd_d      = pop ? ptr_inc(rd_q) : rd_q;
    cnt_d     = cnt_q + CntBits'(push_n) - CntBits'(pop);
    out_vld_d = pop ? 1'b1 : (tok_o.ready ? 1'b0 : out_vld_q);
  end

  always_ff @(posedge clk_i) begin
    if (tok_a_vld_i) begin
      mem_q[wr_q] <= tok_a_i;
    end
    if (tok_b_vld_i) begin
      mem_q[tok_a_vld_i ? wr_next : wr_q] <= tok_b_i;
    end
    if (pop) begin
      out_q <= mem_q[rd_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q      <= '0;
      rd_q      <= '0;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      wr_q      <= wr_d;
      rd_q      <= rd_d;
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign tok_o.valid        = out_vld_q;
  assign tok_o.token_kind   = out_q.token_kind;
  assign tok_o.op_code      = out_q.op_code;
  assign tok_o.start_res    = out_q.start_res;
  assign tok_o.length       = out_q.length;
  assign tok_o.number_value = out_q.number_value;
  assign tok_o.saturated    = out_q.saturated;
  assign tok_o.last         = out_q.last;

endmodule

[hw/rtl/c_subset_lexer_top.sv]
// Accepts one source byte per cycle while the queue has room; the lexer advances per byte.
// A token is queued with its closing byte, then reaches the output register after older ones.
// A byte may release two tokens; they wait in a four-entry token queue, and input ready
// drops while more than two tokens are queued, so input pace follows output draining.
// Reset is asynchronous and active low and clears the lexer state and the queue.
// The end marker returns the lexer to idle mode and position zero after the end token.
`timescale 1ns / 1ps
module c_subset_lexer_top import clx_pkg::*; #(
  parameter int POSITION_BITS = POSITION_BITS_DEF,
  parameter int VALUE_BITS    = VALUE_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  clx_in_if.sink    src_i,
  clx_tok_if.source tok_o
);

  typedef struct packed {
    logic [3:0]               token_kind;
    logic [3:0]               op_code;
    logic [POSITION_BITS-1:0] start_res;
    logic [POSITION_BITS-1:0] length;
    logic [VALUE_BITS-1:0]    number_value;
    logic                     saturated;
    logic                     last;
  } tok_t;

  tok_t tok_a, tok_b;
  logic tok_a_vld, tok_b_vld;
  logic queue_room;

  clx_front #(
    .PosBits (POSITION_BITS),
    .ValBits (VALUE_BITS),
    .tok_t   (tok_t)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .src_i        (src_i),
    .queue_room_i (queue_room),
    .tok_a_o      (tok_a),
    .tok_a_vld_o  (tok_a_vld),
    .tok_b_o      (tok_b),
    .tok_b_vld_o  (tok_b_vld)
  );

  clx_queue #(
    .tok_t (tok_t)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_a_i     (tok_a),
    .tok_a_vld_i (tok_a_vld),
    .tok_b_i     (tok_b),
    .tok_b_vld_i (tok_b_vld),
    .room_o      (queue_room),
    .tok_o       (tok_o)
  );

endmodule

[hw/rtl/clx_checker.sv]
`timescale 1ns / 1ps
module clx_checker import clx_pkg::*; #(
  parameter int PosBits = POSITION_BITS_DEF,
  parameter int ValBits = VALUE_BITS_DEF
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               valid_i,
  input logic               ready_i,
  input logic [3:0]         token_kind_i,
  input logic [3:0]         op_code_i,
  input logic [PosBits-1:0] length_i,
  input logic [ValBits-1:0] number_value_i,
  input logic               saturated_i,
  input logic               last_i
);

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !ready_i |=> valid_i)
    else $error("Token request dropped before it was taken.");

  a_last_is_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> (last_i == (token_kind_i == KIND_END)) &&
                (!last_i || length_i == '0))
    else $error("Last flag does not match an empty end token.");

  a_op_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i |-> ((token_kind_i == KIND_OP) == (op_code_i != OP_NONE)))
    else $error("Operator code does not match token kind.");

  a_number_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && token_kind_i != KIND_NUMBER |-> number_value_i == '0 && !saturated_i)
    else $error("Value fields set on a token that is not a number.");

  a_sat_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && saturated_i |-> number_value_i == '1)
    else $error("Saturated number does not hold the maximum value.");

endmodule

bind c_subset_lexer_top clx_checker #(
  .PosBits (POSITION_BITS),
  .ValBits (VALUE_BITS)
) u_clx_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .valid_i        (tok_o.valid),
  .ready_i        (tok_o.ready),
  .token_kind_i   (tok_o.token_kind),
  .op_code_i      (tok_o.op_code),
  .length_i       (tok_o.length),
  .number_value_i (tok_o.number_value),
  .saturated_i    (tok_o.saturated),
  .last_i         (tok_o.last)
);
